// ----- rtl/bsis_pkg.sv -----
// ----------------------------------------------------------------------------
// bsis_pkg
// Shared types and constants of the barometer I2C sequencer.
// ----------------------------------------------------------------------------
package bsis_pkg;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_CHECK = 3'd1,
    REQ_RESET = 3'd2,
    REQ_CONV  = 3'd3,
    REQ_RDREG = 3'd4,
    REQ_WRREG = 3'd5,
    REQ_RDDAT = 3'd6,
    REQ_NONE  = 3'd7
  } req_t;

  typedef enum logic [3:0] {
    SEG_END   = 4'd0,
    SEG_START = 4'd1,
    SEG_STOP  = 4'd2,
    SEG_SENDW = 4'd3,
    SEG_SENDR = 4'd4,
    SEG_SENDC = 4'd5,
    SEG_SENDV = 4'd6,
    SEG_SENDD = 4'd7,
    SEG_WAIT  = 4'd8,
    SEG_READ  = 4'd9,
    SEG_ACK   = 4'd10,
    SEG_NACK  = 4'd11
  } seg_t;

  localparam logic        CFG_IDX_ADDR = 1'b0;
  localparam logic        CFG_IDX_CONV = 1'b1;
  localparam logic [6:0]  ADDR_RESET   = 7'd118;
  localparam logic [7:0]  CONV_RESET   = 8'h40;
  localparam logic [7:0]  CMD_RESET    = 8'h06;
  localparam logic [7:0]  CMD_RDREG    = 8'h80;
  localparam logic [7:0]  CMD_WRREG    = 8'hC0;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] dev_address;
    logic [5:0] sensor_reg;
    logic [7:0] reg_value;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic               scl_out;
    logic               sda_out;
    logic               busy_res;
    logic               done_res;
    logic [3:0]         status;
    logic [7:0]         read_byte;
    logic               value_valid;
    logic [1:0]         value_kind;
    logic signed [19:0] value_data;
  } out_item_t;

  // Bus segment at position p of the plan of an operation.
  function automatic seg_t plan_seg(input logic [2:0] op, input logic [5:0] p);
    seg_t s;
    s = SEG_END;
    case (op)
      REQ_CHECK: begin
        case (p)
          6'd0: s = SEG_STOP;
          6'd1: s = SEG_START;
          6'd2: s = SEG_SENDD;
          6'd3: s = SEG_WAIT;
          6'd4: s = SEG_STOP;
          default: s = SEG_END;
        endcase
      end
      REQ_RESET, REQ_CONV: begin
        case (p)
          6'd0: s = SEG_START;
          6'd1: s = SEG_SENDW;
          6'd2: s = SEG_WAIT;
          6'd3: s = SEG_SENDC;
          6'd4: s = SEG_WAIT;
          6'd5: s = SEG_STOP;
          default: s = SEG_END;
        endcase
      end
      REQ_RDREG: begin
        case (p)
          6'd0: s = SEG_START;
          6'd1: s = SEG_SENDW;
          6'd2: s = SEG_WAIT;
          6'd3: s = SEG_SENDC;
          6'd4: s = SEG_WAIT;
          6'd5: s = SEG_STOP;
          6'd6: s = SEG_START;
          6'd7: s = SEG_SENDR;
          6'd8: s = SEG_WAIT;
          6'd9: s = SEG_READ;
          6'd10: s = SEG_NACK;
          6'd11: s = SEG_STOP;
          default: s = SEG_END;
        endcase
      end
      REQ_WRREG: begin
        case (p)
          6'd0: s = SEG_START;
          6'd1: s = SEG_SENDW;
          6'd2: s = SEG_WAIT;
          6'd3: s = SEG_SENDC;
          6'd4: s = SEG_WAIT;
          6'd5: s = SEG_SENDV;
          6'd6: s = SEG_WAIT;
          6'd7: s = SEG_STOP;
          default: s = SEG_END;
        endcase
      end
      REQ_RDDAT: begin
        case (p)
          6'd0: s = SEG_START;
          6'd1: s = SEG_SENDW;
          6'd2: s = SEG_WAIT;
          6'd3: s = SEG_SENDC;
          6'd4: s = SEG_WAIT;
          6'd5: s = SEG_STOP;
          6'd6: s = SEG_START;
          6'd7: s = SEG_SENDR;
          6'd8: s = SEG_WAIT;
          6'd9: s = SEG_READ;
          6'd10: s = SEG_ACK;
          6'd11: s = SEG_READ;
          6'd12: s = SEG_ACK;
          6'd13: s = SEG_READ;
          6'd14: s = SEG_NACK;
          6'd15: s = SEG_STOP;
          default: s = SEG_END;
        endcase
      end
      default: s = SEG_END;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] meas_cmd(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h30;
      2'd1: c = 8'h32;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/bsis_core.sv -----
// ----------------------------------------------------------------------------
// bsis_core
// Sequencer state and one bus phase of work per accepted item.
// ----------------------------------------------------------------------------
module bsis_core import bsis_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_item_t   item,
  input  logic [6:0] sensor_address,
  input  logic [7:0] conv_command,
  output out_item_t  res
);

  logic [5:0]  phase_r, phase_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_reg_r, shift_reg_nxt;
  logic [1:0]  meas_index_r, meas_index_nxt;
  logic [23:0] sample_buf_r, sample_buf_nxt;
  logic [2:0]  op_r, op_nxt;
  logic        scl_r, scl_nxt, sda_r, sda_nxt;
  logic [15:0] args_r, args_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic        ackh_r, ackh_nxt;
  logic [3:0]  ackn_r, ackn_nxt;

  // working copies after a possible command load
  logic [2:0]  op;
  logic [15:0] args;
  logic [5:0]  ph;
  logic [1:0]  sub;
  logic [3:0]  bc;
  logic [1:0]  mi;
  logic        ah;
  logic [3:0]  an;
  seg_t        seg, seg_next;
  logic [7:0]  sbyte;
  logic [3:0]  bc_inc;
  logic        scl, sda, fin, early;
  logic [7:0]  sr_shift;
  logic [23:0] sb_shift;
  logic [3:0]  an_inc;

  always_comb begin
    logic load;
    load = (op_r == 3'd0) && (item.req_type != REQ_TICK) && (item.req_type != REQ_NONE);
    op   = load ? item.req_type : op_r;
    args = load ? ((item.req_type == REQ_CHECK) ? {8'd0, item.dev_address}
                                                : {2'd0, item.sensor_reg, item.reg_value})
                : args_r;
    ph   = load ? 6'd0 : phase_r;
    sub  = load ? 2'd0 : sub_r;
    bc   = load ? 4'd0 : bit_count_r;
    mi   = load ? 2'd0 : meas_index_r;
    ah   = load ? 1'b0 : ackh_r;
    an   = load ? 4'd0 : ackn_r;
  end

  always_comb begin
    seg = plan_seg(op, ph);
    case (seg)
      SEG_SENDW: sbyte = {sensor_address, 1'b0};
      SEG_SENDR: sbyte = {sensor_address, 1'b1};
      SEG_SENDV, SEG_SENDD: sbyte = args[7:0];
      default: begin
        case (op)
          REQ_RESET: sbyte = CMD_RESET;
          REQ_CONV:  sbyte = conv_command;
          REQ_RDREG: sbyte = CMD_RDREG | {2'd0, args[13:8]};
          REQ_WRREG: sbyte = CMD_WRREG | {2'd0, args[13:8]};
          default:   sbyte = meas_cmd(mi);
        endcase
      end
    endcase
    bc_inc   = bc + 4'd1;
    sr_shift = {shift_reg_r[6:0], item.sda_in};
    sb_shift = {sample_buf_r[15:0], shift_reg_r};
    an_inc   = an + 4'd1;
    seg_next = plan_seg(op, ph + 6'd1);
  end

  always_comb begin
    phase_nxt = ph; bit_count_nxt = bc; shift_reg_nxt = shift_reg_r;
    meas_index_nxt = mi; sample_buf_nxt = sample_buf_r; op_nxt = op;
    scl_nxt = scl_r; sda_nxt = sda_r; args_nxt = args; sub_nxt = sub;
    ackh_nxt = ah; ackn_nxt = an;
    res = '0;
    res.scl_out = scl_r;
    res.sda_out = sda_r;
    scl = 1'b0; sda = 1'b1; fin = 1'b0; early = 1'b0;
    if (op != 3'd0) begin
      case (seg)
        SEG_START: begin
          scl = (sub < 2'd2); sda = (sub == 2'd0); fin = (sub >= 2'd2);
        end
        SEG_STOP: begin
          scl = 1'b1; sda = (sub != 2'd0); fin = (sub >= 2'd1);
        end
        SEG_SENDW, SEG_SENDR, SEG_SENDC, SEG_SENDV, SEG_SENDD: begin
          scl = (sub == 2'd1);
          sda = (sub >= 2'd2 && bc >= 4'd7) ? 1'b1 : sbyte[3'd7 - bc[2:0]];
          if (sub >= 2'd2) begin
            bit_count_nxt = bc_inc;
            fin = bc_inc >= 4'd8;
            early = !fin;
          end
        end
        SEG_WAIT: begin
          scl = (sub == 2'd1);
          if (sub == 2'd1) ackh_nxt = item.sda_in;
          fin = (sub >= 2'd2);
        end
        SEG_READ: begin
          scl = (sub == 2'd0);
          if (sub == 2'd0) begin
            shift_reg_nxt = sr_shift;
          end else begin
            bit_count_nxt = bc_inc;
            fin = bc_inc >= 4'd8;
            early = !fin;
            if (fin) sample_buf_nxt = sb_shift;
          end
        end
        SEG_ACK: begin
          scl = (sub == 2'd1); sda = 1'b0; fin = (sub >= 2'd2);
        end
        SEG_NACK: begin
          scl = (sub == 2'd1); fin = (sub >= 2'd2);
        end
        default: ;
      endcase
      if (seg == SEG_END) begin
        // plan exhausted without a finishing phase: drop back to idle
        op_nxt = 3'd0; phase_nxt = '0; sub_nxt = '0; bit_count_nxt = '0;
      end else begin
        scl_nxt = scl; sda_nxt = sda;
        res.scl_out = scl; res.sda_out = sda; res.busy_res = 1'b1;
        if (early) begin
          sub_nxt = 2'd0;
        end else if (!fin) begin
          sub_nxt = sub + 2'd1;
        end else begin
          sub_nxt = 2'd0; bit_count_nxt = 4'd0;
          if (seg == SEG_WAIT) ackn_nxt = an_inc;
          if (seg == SEG_WAIT && ackh_nxt && op != REQ_CHECK) begin
            res.done_res = 1'b1; res.status = an_inc;
            op_nxt = 3'd0; phase_nxt = '0;
          end else begin
            phase_nxt = ph + 6'd1;
            if (seg_next == SEG_END) begin
              if (op == REQ_RDDAT) begin
                res.value_valid = 1'b1;
                res.value_kind  = mi;
                res.value_data  = sample_buf_nxt[19:0];
              end
              if (op == REQ_RDDAT && mi < 2'd2) begin
                meas_index_nxt = mi + 2'd1;
                phase_nxt = 6'd0;
              end else begin
                res.done_res = 1'b1;
                if (op == REQ_CHECK) res.status = {3'd0, ackh_nxt};
                if (op == REQ_RDREG) res.read_byte = shift_reg_nxt;
                op_nxt = 3'd0; phase_nxt = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0; bit_count_r <= '0; shift_reg_r <= '0; meas_index_r <= '0;
      sample_buf_r <= '0; op_r <= '0; scl_r <= 1'b1; sda_r <= 1'b1;
      args_r <= '0; sub_r <= '0; ackh_r <= 1'b0; ackn_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; bit_count_r <= bit_count_nxt;
      shift_reg_r <= shift_reg_nxt; meas_index_r <= meas_index_nxt;
      sample_buf_r <= sample_buf_nxt; op_r <= op_nxt;
      scl_r <= scl_nxt; sda_r <= sda_nxt; args_r <= args_nxt;
      sub_r <= sub_nxt; ackh_r <= ackh_nxt; ackn_r <= ackn_nxt;
    end
  end

endmodule

// ----- rtl/baro_sensor_i2c_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// baro_sensor_i2c_sequencer_top
// Bit-level I2C master for barometer transactions, one bus phase per item.
// ----------------------------------------------------------------------------
// Result: the result of an item is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle while not stalled; the sequencer state update
//   is a single register step, and the output register is refilled as it drains.
// Reset: synchronous, active low; lines released, sequencer idle, config
//   registers back to address 118 and conversion command 0x40.
module baro_sensor_i2c_sequencer_top import bsis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);

  logic [6:0] addr_r;
  logic [7:0] conv_r;
  logic       step;
  out_item_t  res;
  logic       out_valid_r;
  out_item_t  out_data_r;

  // Take an item whenever the result register is empty or drains this cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign step      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes; indexes past the list are absorbed by width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
      conv_r <= CONV_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_ADDR) addr_r <= cfg_data[6:0];
      if (cfg_index == CFG_IDX_CONV) conv_r <= cfg_data;
    end
  end

  bsis_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .item           (in_data),
    .sensor_address (addr_r),
    .conv_command   (conv_r),
    .res            (res)
  );

  // Result register: load on each accepted item, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_data_r <= res;
  end

endmodule

// ----- rtl/bsis_checker.sv -----
// ----------------------------------------------------------------------------
// bsis_checker
// Port-level checks of the barometer I2C sequencer.
// ----------------------------------------------------------------------------
module bsis_checker import bsis_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done without busy");

  a_value_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_valid |-> out_data.busy_res && out_data.value_kind != 2'd3)
    else $error("bad measurement item");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

endmodule

bind baro_sensor_i2c_sequencer_top bsis_checker u_bsis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
